FILE: sv/pcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types and constants of the permutation crossover/mutation core.
// ----------------------------------------------------------------------------
package pcm_pkg;

	localparam int LETTER_W       = 5;
	localparam int POS_W          = 5;
	localparam int MASK_W         = 2 ** LETTER_W;
	localparam int ALPHABET_SIZE  = 25;
	localparam int KEY_LENGTH_DEF = 25;
	localparam int MODE_W         = 2;

	// mutation modes; other codes leave the child alone
	localparam logic [MODE_W-1:0] MUT_SWAP    = 2'd0;
	localparam logic [MODE_W-1:0] MUT_REVERSE = 2'd1;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_BUILD,
		ST_READ,
		ST_SHOW
	} pcm_state_t;

	// contents of one position cell
	typedef struct packed {
		logic [LETTER_W-1:0] p1;
		logic [LETTER_W-1:0] p2;
		logic                keep;
	} cell_data_t;

	// per-cell control: load write, advance first-parent lane, advance second-parent lane
	typedef struct packed {
		logic wr;
		logic adv_a;
		logic adv_b;
	} cell_ctrl_t;

endpackage

FILE: sv/pcm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_if
// Valid/ready channel interfaces: parent positions in, child letters out,
// mutation mode configuration.
// ----------------------------------------------------------------------------
interface pcm_item_if import pcm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [LETTER_W-1:0] parent_one_letter;
	logic [LETTER_W-1:0] parent_two_letter;
	logic                keep_flag;
	logic [POS_W-1:0]    first_position;
	logic [POS_W-1:0]    second_position;
	logic                last_item;

	modport source (
		output valid, parent_one_letter, parent_two_letter, keep_flag,
		output first_position, second_position, last_item,
		input  ready
	);
	modport sink (
		input  valid, parent_one_letter, parent_two_letter, keep_flag,
		input  first_position, second_position, last_item,
		output ready
	);
endinterface

interface pcm_result_if import pcm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [LETTER_W-1:0] child_letter;
	logic                final_letter;
	logic                invalid_child;

	modport source (output valid, child_letter, final_letter, invalid_child, input ready);
	modport sink   (input  valid, child_letter, final_letter, invalid_child, output ready);
endinterface

interface pcm_cfg_if import pcm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mutation_mode;

	modport source (output valid, mutation_mode, input ready);
	modport sink   (input  valid, mutation_mode, output ready);
endinterface

FILE: sv/pcm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_cell
// One position of the parent chain: holds both parent letters and the keep
// bit, takes the neighbor's contents when its lane advances.
// ----------------------------------------------------------------------------
module pcm_cell import pcm_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  cell_data_t wr_data,
	input  cell_data_t nxt_data,
	output cell_data_t data
);

	cell_data_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			data_q <= wr_data;
		end else begin
			if (ctrl.adv_a) begin
				data_q.p1   <= nxt_data.p1;
				data_q.keep <= nxt_data.keep;
			end
			if (ctrl.adv_b) begin
				data_q.p2 <= nxt_data.p2;
			end
		end
	end

	assign data = data_q;

endmodule

FILE: sv/permutation_crossover_mutation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_crossover_mutation_core
// Uniform order-based crossover of two permutation keys followed by a swap
// or range-reversal mutation; emits the child one letter per transaction.
// ----------------------------------------------------------------------------
//  channel     dir  handshake     payload
//  item_in     in   valid/ready   parent letters, keep flag, positions, last
//  result_out  out  valid/ready   child letter, final flag, invalid flag
//  cfg         in   valid/ready   mutation_mode (ready always high)
//
//  Load: one position per cycle into a chain of KEY_LENGTH cells.
//  Build: after the last item the chain drains through its head cell, one
//    step per cycle; each step either produces one child letter or skips a
//    second-parent letter that was already kept.
//  Emit: each letter is read from the child RAM, then held in the output register.
//  Reset clears control state only; cell and RAM contents are don't-care.
//  item_in is not ready until the last letter of the previous child is taken;
//  a stalled result_out holds the letter and freezes the emit sequence.
// ----------------------------------------------------------------------------
module permutation_crossover_mutation_core import pcm_pkg::*; #(
	parameter int KEY_LENGTH = KEY_LENGTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	pcm_item_if.sink       item_in,
	pcm_result_if.source   result_out,
	pcm_cfg_if.sink        cfg
);

	localparam int CNT_W  = $clog2(KEY_LENGTH + 1);  // holds 0..KEY_LENGTH
	localparam int IDX_W  = $clog2(KEY_LENGTH);      // position index
	localparam int ADDR_W = POS_W + 2;               // reversal address math

	pcm_state_t state_q, state_d;

	// configuration
	logic [MODE_W-1:0] mode_q;

	// load side
	logic [CNT_W-1:0]  load_cnt_q;
	logic [MASK_W-1:0] kept_q;      // letters kept from the first parent

	// build side
	logic [CNT_W-1:0]  n_q;         // child length
	logic [CNT_W-1:0]  src_q;       // second-parent letters consumed
	logic [IDX_W-1:0]  i_q;         // child position being filled
	logic [MASK_W-1:0] seen_q;      // child letters produced so far
	logic              bad_q;

	// mutation, sampled with the last item
	logic              mut_swap_q;
	logic              mut_rev_q;
	logic [POS_W-1:0]  pos_a_q;
	logic [POS_W-1:0]  pos_b_q;
	logic [POS_W-1:0]  lo_q;
	logic [POS_W-1:0]  hi_q;

	// emit side
	logic [IDX_W-1:0]    j_q;
	logic [LETTER_W-1:0] rd_q;
	logic [LETTER_W-1:0] child_mem [KEY_LENGTH];

	// ---------------------------------------------------------------- handshakes
	logic in_acc, last_acc, out_acc, store_ok;
	logic [CNT_W-1:0] n_next;

	assign in_acc   = item_in.valid & item_in.ready;
	assign last_acc = in_acc & item_in.last_item;
	assign out_acc  = result_out.valid & result_out.ready;
	assign store_ok = (load_cnt_q != CNT_W'(KEY_LENGTH));
	assign n_next   = store_ok ? load_cnt_q + CNT_W'(1) : load_cnt_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MUT_SWAP;
		end else if (cfg.valid) begin
			mode_q <= cfg.mutation_mode;
		end
	end

	// ---------------------------------------------------------------- cell chain
	cell_data_t cell_q [KEY_LENGTH];
	cell_data_t head;
	cell_data_t wr_data;
	logic       adv_a, adv_b;

	assign wr_data.p1   = item_in.parent_one_letter;
	assign wr_data.p2   = item_in.parent_two_letter;
	assign wr_data.keep = item_in.keep_flag;
	assign head         = cell_q[0];

	for (genvar k = 0; k < KEY_LENGTH; k++) begin : g_cell
		cell_ctrl_t ctrl;
		cell_data_t nxt;

		assign ctrl.wr    = in_acc & store_ok & (load_cnt_q == CNT_W'(k));
		assign ctrl.adv_a = adv_a;
		assign ctrl.adv_b = adv_b;

		if (k == KEY_LENGTH - 1) begin : g_tail
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_q[k+1];
		end

		pcm_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.wr_data  (wr_data),
			.nxt_data (nxt),
			.data     (cell_q[k])
		);
	end

	// ---------------------------------------------------------------- build step
	// Head cell holds child position i (lane a) and the next unused
	// second-parent letter (lane b). Each cycle either skips a kept letter
	// on lane b or produces one child letter.
	logic                src_ok, skip, produce, exhaust, dup, build_done;
	logic [LETTER_W-1:0] letter;

	assign src_ok  = (src_q < n_q);
	assign skip    = !head.keep && src_ok && kept_q[head.p2];
	assign produce = (state_q == ST_BUILD) && !skip;
	assign exhaust = !head.keep && !src_ok;
	assign adv_a   = produce;
	assign adv_b   = (state_q == ST_BUILD) && !head.keep && src_ok;

	always_comb begin
		if (head.keep) begin
			letter = head.p1;
		end else if (src_ok) begin
			letter = head.p2;
		end else begin
			letter = '0;
		end
	end

	assign dup        = seen_q[letter];
	assign build_done = produce && ((CNT_W'(i_q) + CNT_W'(1)) == n_q);

	always_ff @(posedge clk) begin
		if (produce) begin
			child_mem[i_q] <= letter;
		end
	end

	// ---------------------------------------------------------------- emit address
	// Mutation is applied as an address remap on the child RAM read.
	logic [POS_W-1:0]  j_pos;
	logic [ADDR_W-1:0] rev_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              last_out;

	assign j_pos    = POS_W'(j_q);
	assign rev_addr = ADDR_W'(lo_q) + ADDR_W'(hi_q) - ADDR_W'(1) - ADDR_W'(j_pos);
	assign last_out = ((CNT_W'(j_q) + CNT_W'(1)) == n_q);

	always_comb begin
		rd_addr = ADDR_W'(j_pos);
		if (mut_swap_q) begin
			if (j_pos == pos_a_q) begin
				rd_addr = ADDR_W'(pos_b_q);
			end else if (j_pos == pos_b_q) begin
				rd_addr = ADDR_W'(pos_a_q);
			end
		end else if (mut_rev_q && (j_pos >= lo_q) && (j_pos < hi_q)) begin
			rd_addr = rev_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q <= child_mem[rd_addr[IDX_W-1:0]];
		end
	end

	// ---------------------------------------------------------------- mutation setup
	logic mut_ok;

	assign mut_ok = (item_in.first_position != item_in.second_position)
		&& (32'(item_in.first_position) < 32'(n_next))
		&& (32'(item_in.second_position) < 32'(n_next));

	always_ff @(posedge clk) begin
		if (last_acc) begin
			pos_a_q    <= item_in.first_position;
			pos_b_q    <= item_in.second_position;
			mut_swap_q <= mut_ok && (mode_q == MUT_SWAP);
			mut_rev_q  <= mut_ok && (mode_q == MUT_REVERSE);
			if (item_in.first_position < item_in.second_position) begin
				lo_q <= item_in.first_position;
				hi_q <= item_in.second_position;
			end else begin
				lo_q <= item_in.second_position;
				hi_q <= item_in.first_position;
			end
		end
	end

	// ---------------------------------------------------------------- control regs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			kept_q     <= '0;
			n_q        <= '0;
			src_q      <= '0;
			i_q        <= '0;
			seen_q     <= '0;
			bad_q      <= 1'b0;
			j_q        <= '0;
		end else begin
			if (in_acc) begin
				if (item_in.last_item) begin
					load_cnt_q <= '0;
				end else begin
					load_cnt_q <= n_next;
				end
				if (store_ok && item_in.keep_flag) begin
					kept_q[item_in.parent_one_letter] <= 1'b1;
				end
			end

			if (last_acc) begin
				n_q    <= n_next;
				src_q  <= '0;
				i_q    <= '0;
				seen_q <= '0;
				bad_q  <= (32'(n_next) != 32'(ALPHABET_SIZE));
			end else begin
				if (adv_b) begin
					src_q <= src_q + CNT_W'(1);
				end
				if (produce) begin
					i_q            <= i_q + IDX_W'(1);
					seen_q[letter] <= 1'b1;
					if (exhaust || dup || (32'(letter) >= 32'(ALPHABET_SIZE))) begin
						bad_q <= 1'b1;
					end
				end
			end

			if (build_done) begin
				kept_q <= '0;
				j_q    <= '0;
			end else if (out_acc && !last_out) begin
				j_q <= j_q + IDX_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------- state machine
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (last_acc)   state_d = ST_BUILD;
			ST_BUILD: if (build_done) state_d = ST_READ;
			ST_READ:  state_d = ST_SHOW;
			ST_SHOW: begin
				if (out_acc) begin
					state_d = last_out ? ST_LOAD : ST_READ;
				end
			end
			default:  state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		item_in.ready            = (state_q == ST_LOAD);
		result_out.valid         = (state_q == ST_SHOW);
		result_out.child_letter  = rd_q;
		result_out.final_letter  = last_out;
		result_out.invalid_child = bad_q;
	end

	// ---------------------------------------------------------------- assertions
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(item_in.ready && result_out.valid))
		else $error("load and emit overlap");

	a_src_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUILD) |-> (src_q <= n_q))
		else $error("second-parent pointer past child length");

	a_build_idx: assert property (@(posedge clk) disable iff (!arst_n)
		produce |-> ((CNT_W'(i_q) + CNT_W'(1)) <= n_q))
		else $error("child write beyond child length");

	a_kept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		build_done |=> (kept_q == '0) && (load_cnt_q == '0))
		else $error("load state not cleared after build");

endmodule
